// ===== rtl/wsmd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsmd_pkg
// Shared types and constants of the wav stream mono downmixer.
// ----------------------------------------------------------------------------
package wsmd_pkg;

   // result kinds
   localparam logic [1:0] KIND_INFO   = 2'd0;
   localparam logic [1:0] KIND_SAMPLE = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // format codes
   localparam logic [2:0] FMT_NONE     = 3'd0;
   localparam logic [2:0] FMT_MONO8    = 3'd1;
   localparam logic [2:0] FMT_MONO16   = 3'd2;
   localparam logic [2:0] FMT_STEREO8  = 3'd3;
   localparam logic [2:0] FMT_STEREO16 = 3'd4;

   // error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_NO_RIFF   = 3'd1;
   localparam logic [2:0] ERR_NO_WAVE   = 3'd2;
   localparam logic [2:0] ERR_NO_DATA   = 3'd3;
   localparam logic [2:0] ERR_TRUNCATED = 3'd4;

   // header tags, big-endian as they arrive in the tag window
   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      OP_INFO,
      OP_ERROR,
      OP_MONO8,
      OP_MONO16,
      OP_STEREO8,
      OP_STEREO16
   } op_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] sample;
      logic [7:0]         channels;
      logic [31:0]        sample_rate;
      logic [7:0]         bits_per_sample;
      logic [31:0]        data_size;
      logic [2:0]         format_code;
      logic [2:0]         error_code;
   } rsp_type;

   // one classified word handed from front to back
   typedef struct packed {
      op_type      op;
      logic [23:0] frame;
      logic [7:0]  data_byte;
      logic [7:0]  channels;
      logic [31:0] sample_rate;
      logic [7:0]  bits_per_sample;
      logic [31:0] data_size;
      logic [2:0]  format_code;
      logic [2:0]  error_code;
   } job_type;

endpackage

// ===== rtl/wsmd_front.sv =====
// ----------------------------------------------------------------------------
// wsmd_front
// Header parser and frame collector: takes one byte a cycle while accept is high and classifies
// it into a job for the back end, or into nothing.
// ----------------------------------------------------------------------------
module wsmd_front
   import wsmd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   output logic    job_valid,
   output job_type job
);

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_SKIP    = 2'd2
   } phase_type;

   localparam logic [5:0] POS_RIFF_END = 6'd3;
   localparam logic [5:0] POS_WAVE_END = 6'd11;
   localparam logic [5:0] POS_CHANNELS = 6'd22;
   localparam logic [5:0] POS_BITS     = 6'd34;
   localparam logic [5:0] POS_DATA_END = 6'd39;
   localparam logic [5:0] POS_LAST     = 6'd43;

   phase_type   phase_ff, phase_in;
   logic [5:0]  hdr_pos_ff, hdr_pos_in;
   logic [31:0] tag_ff, tag_in;
   logic [7:0]  channel_ff, channel_in;
   logic [31:0] rate_ff, rate_in;
   logic [7:0]  bits_ff, bits_in;
   logic [31:0] remaining_ff, remaining_in;
   logic [23:0] frame_ff, frame_in;
   logic [1:0]  frame_pos_ff, frame_pos_in;

   logic [31:0] tag_new;
   logic [7:0]  b;
   logic [2:0]  fmt;
   logic [2:0]  need;
   logic [2:0]  have;

   function automatic logic [2:0] format_of(input logic [7:0] ch, input logic [7:0] bits);
      logic [2:0] f;
      f = FMT_NONE;
      if (ch == 8'd1) begin
         if (bits == 8'd8) f = FMT_MONO8;
         else if (bits == 8'd16) f = FMT_MONO16;
      end else if (ch == 8'd2) begin
         if (bits == 8'd8) f = FMT_STEREO8;
         else if (bits == 8'd16) f = FMT_STEREO16;
      end
      return f;
   endfunction

   assign b       = req.data_byte;
   assign tag_new = {tag_ff[23:0], b};
   assign fmt     = format_of(channel_ff, bits_ff);
   assign have    = {1'b0, frame_pos_ff} + 3'd1;

   always_comb begin
      case (fmt)
         FMT_MONO8:    need = 3'd1;
         FMT_STEREO16: need = 3'd4;
         default:      need = 3'd2;
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      hdr_pos_in   = hdr_pos_ff;
      tag_in       = tag_ff;
      channel_in   = channel_ff;
      rate_in      = rate_ff;
      bits_in      = bits_ff;
      remaining_in = remaining_ff;
      frame_in     = frame_ff;
      frame_pos_in = frame_pos_ff;
      job_valid    = 1'b0;
      job          = '0;
      job.op       = OP_INFO;
      if (accept) begin
         case (phase_ff)
            PH_HEADER: begin
               tag_in = tag_new;
               if (hdr_pos_ff == POS_RIFF_END && tag_new != TAG_RIFF) begin
                  phase_in       = PH_SKIP;
                  job_valid      = 1'b1;
                  job.op         = OP_ERROR;
                  job.error_code = ERR_NO_RIFF;
               end else if (hdr_pos_ff == POS_WAVE_END && tag_new != TAG_WAVE) begin
                  phase_in       = PH_SKIP;
                  job_valid      = 1'b1;
                  job.op         = OP_ERROR;
                  job.error_code = ERR_NO_WAVE;
               end else if (hdr_pos_ff == POS_DATA_END && tag_new != TAG_DATA) begin
                  phase_in       = PH_SKIP;
                  job_valid      = 1'b1;
                  job.op         = OP_ERROR;
                  job.error_code = ERR_NO_DATA;
               end else begin
                  if (hdr_pos_ff == POS_CHANNELS) channel_in = b;
                  if (hdr_pos_ff == POS_BITS) bits_in = b;
                  // little-endian rate and size fields
                  case (hdr_pos_ff)
                     6'd24:   rate_in = {24'd0, b};
                     6'd25:   rate_in[15:8] = b;
                     6'd26:   rate_in[23:16] = b;
                     6'd27:   rate_in[31:24] = b;
                     6'd40:   remaining_in = {24'd0, b};
                     6'd41:   remaining_in[15:8] = b;
                     6'd42:   remaining_in[23:16] = b;
                     6'd43:   remaining_in[31:24] = b;
                     default: ;
                  endcase
                  if (hdr_pos_ff == POS_LAST) begin
                     phase_in            = PH_PAYLOAD;
                     frame_in            = '0;
                     frame_pos_in        = '0;
                     job_valid           = 1'b1;
                     job.op              = OP_INFO;
                     job.channels        = channel_ff;
                     job.sample_rate     = rate_in;
                     job.bits_per_sample = bits_ff;
                     job.data_size       = remaining_in;
                     job.format_code     = fmt;
                  end else begin
                     hdr_pos_in = hdr_pos_ff + 6'd1;
                     if (req.last_byte) begin
                        job_valid      = 1'b1;
                        job.op         = OP_ERROR;
                        job.error_code = ERR_TRUNCATED;
                     end
                  end
               end
            end
            PH_PAYLOAD: begin
               if (remaining_ff != '0) begin
                  remaining_in = remaining_ff - 32'd1;
                  if (fmt != FMT_NONE) begin
                     if (have < need) begin
                        case (frame_pos_ff)
                           2'd0:    frame_in[7:0] = b;
                           2'd1:    frame_in[15:8] = b;
                           2'd2:    frame_in[23:16] = b;
                           default: ;
                        endcase
                        frame_pos_in = frame_pos_ff + 2'd1;
                     end else begin
                        frame_in      = '0;
                        frame_pos_in  = '0;
                        job_valid     = 1'b1;
                        job.frame     = frame_ff;
                        job.data_byte = b;
                        case (fmt)
                           FMT_MONO8:   job.op = OP_MONO8;
                           FMT_MONO16:  job.op = OP_MONO16;
                           FMT_STEREO8: job.op = OP_STEREO8;
                           default:     job.op = OP_STEREO16;
                        endcase
                     end
                  end
               end
            end
            default: ;
         endcase
         if (req.last_byte) begin
            phase_in     = PH_HEADER;
            hdr_pos_in   = '0;
            tag_in       = '0;
            frame_in     = '0;
            frame_pos_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hdr_pos_ff   <= '0;
         tag_ff       <= '0;
         channel_ff   <= '0;
         rate_ff      <= '0;
         bits_ff      <= '0;
         remaining_ff <= '0;
         frame_ff     <= '0;
         frame_pos_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         hdr_pos_ff   <= hdr_pos_in;
         tag_ff       <= tag_in;
         channel_ff   <= channel_in;
         rate_ff      <= rate_in;
         bits_ff      <= bits_in;
         remaining_ff <= remaining_in;
         frame_ff     <= frame_in;
         frame_pos_ff <= frame_pos_in;
      end
   end

endmodule

// ===== rtl/wsmd_queue.sv =====
// ----------------------------------------------------------------------------
// wsmd_queue
// Short first-in first-out queue of jobs between front and back.
// ----------------------------------------------------------------------------
module wsmd_queue
   import wsmd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  job_type wr_job,
   output logic    full,
   input  logic    rd_en,
   output logic    empty,
   output job_type rd_job
);

   job_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic                  do_wr;
   logic                  do_rd;

   assign full   = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);
   assign rd_job = mem_ff[rd_ptr_ff];
   assign do_wr  = wr_en && !full;
   assign do_rd  = rd_en && !empty;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) count_in = count_ff + QUEUE_CW'(1);
      else if (do_rd && !do_wr) count_in = count_ff - QUEUE_CW'(1);
   end

   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wr_ptr_ff] <= wr_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/wsmd_back.sv =====
// ----------------------------------------------------------------------------
// wsmd_back
// Result builder: forms samples (pass-through or stereo average) and header
// and error words, and holds the oldest result in an output register.
// ----------------------------------------------------------------------------
module wsmd_back
   import wsmd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  job_type q_job,
   output logic    q_pop,
   input  logic    pop,
   output logic    empty,
   output rsp_type rsp_item
);

   logic        out_valid_ff, out_valid_in;
   rsp_type     out_item_ff, out_item_in;
   logic [8:0]  sum8;
   logic [16:0] sum16;
   logic [16:0] adj16;
   logic [15:0] sample;

   assign q_pop    = !q_empty && (!out_valid_ff || pop);
   assign empty    = !out_valid_ff;
   assign rsp_item = out_item_ff;

   assign sum8  = {1'b0, q_job.frame[7:0]} + {1'b0, q_job.data_byte};
   assign sum16 = {q_job.frame[15], q_job.frame[15:0]}
                + {q_job.data_byte[7], q_job.data_byte, q_job.frame[23:16]};
   // add one to a negative sum so the halving truncates toward zero
   assign adj16 = sum16 + {16'd0, sum16[16]};

   always_comb begin
      case (q_job.op)
         OP_MONO8:    sample = {8'd0, q_job.data_byte};
         OP_MONO16:   sample = {q_job.data_byte, q_job.frame[7:0]};
         OP_STEREO8:  sample = {8'd0, sum8[8:1]};
         OP_STEREO16: sample = adj16[16:1];
         default:     sample = '0;
      endcase
   end

   always_comb begin
      out_item_in = '0;
      case (q_job.op)
         OP_INFO: begin
            out_item_in.kind            = KIND_INFO;
            out_item_in.channels        = q_job.channels;
            out_item_in.sample_rate     = q_job.sample_rate;
            out_item_in.bits_per_sample = q_job.bits_per_sample;
            out_item_in.data_size       = q_job.data_size;
            out_item_in.format_code     = q_job.format_code;
         end
         OP_ERROR: begin
            out_item_in.kind       = KIND_ERROR;
            out_item_in.error_code = q_job.error_code;
         end
         default: begin
            out_item_in.kind   = KIND_SAMPLE;
            out_item_in.sample = sample;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (q_pop) out_valid_in = 1'b1;
      else if (pop) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (q_pop) out_item_ff <= out_item_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== rtl/wav_stream_mono_downmixer_unit.sv =====
// a result word is registered in the job queue and then in the output register before it shows on the result ports
// throughput: one byte per cycle while the job queue is not full, set by the header parser and frame collector
// a four-word job queue and one output register decouple input from result side
// reset: synchronous, active high; returns to header parsing with queue and output empty
// ----------------------------------------------------------------------------
// wav_stream_mono_downmixer_unit
// Parses a WAV header from a byte stream and emits header info, errors and
// mono samples, averaging stereo frames.
// ----------------------------------------------------------------------------
module wav_stream_mono_downmixer_unit
   import wsmd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_item,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_item
);

   logic    accept;
   logic    job_valid;
   job_type job;
   logic    q_empty;
   logic    q_pop;
   job_type q_job;

   assign accept = push && !full;

   wsmd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_item),
      .job_valid (job_valid),
      .job       (job)
   );

   wsmd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (job_valid),
      .wr_job (job),
      .full   (full),
      .rd_en  (q_pop),
      .empty  (q_empty),
      .rd_job (q_job)
   );

   wsmd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_job    (q_job),
      .q_pop    (q_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp_item (rsp_item)
   );

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Streams WAV files byte by byte into the mono downmixer, predicts the header
// info, error and sample words, and checks every result word against them.
// ----------------------------------------------------------------------------
module tb_top;
   import wsmd_pkg::*;

   typedef logic [7:0] byte_queue_type[$];
   typedef enum logic [1:0] {PH_HEADER, PH_PAYLOAD, PH_SKIP} parse_phase_type;

   localparam int RANDOM_BYTES = 830;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int LONG_HOLD    = 80;

   class downmix_scoreboard_type;
      parse_phase_type stage  = PH_HEADER;
      int           hdr_pos   = 0;
      logic [31:0]  tag_win   = '0;
      logic [7:0]   chans     = '0;
      logic [31:0]  rate      = '0;
      logic [7:0]   bits      = '0;
      logic [31:0]  remaining = '0;
      logic [23:0]  frame     = '0;
      int           frame_pos = 0;
      rsp_type      pending_words[$];
      int           errors    = 0;

      function logic [2:0] format_now();
         if (chans == 8'd1 && bits == 8'd8) return FMT_MONO8;
         if (chans == 8'd1 && bits == 8'd16) return FMT_MONO16;
         if (chans == 8'd2 && bits == 8'd8) return FMT_STEREO8;
         if (chans == 8'd2 && bits == 8'd16) return FMT_STEREO16;
         return FMT_NONE;
      endfunction

      // one accepted byte: advance the parser copy, queue any word it produces
      function void note_byte(req_type r);
         rsp_type     w;
         bit          hit;
         logic [7:0]  b;
         logic [2:0]  fmt;
         logic [8:0]  sum9;
         logic [15:0] s;
         int          need;
         int          mix;
         w   = '0;
         hit = 0;
         b   = r.data_byte;
         case (stage)
            PH_HEADER: begin
               tag_win = {tag_win[23:0], b};
               if ((hdr_pos == 3 && tag_win != TAG_RIFF) ||
                   (hdr_pos == 11 && tag_win != TAG_WAVE) ||
                   (hdr_pos == 39 && tag_win != TAG_DATA)) begin
                  stage        = PH_SKIP;
                  hit          = 1;
                  w.kind       = KIND_ERROR;
                  w.error_code = (hdr_pos == 3) ? ERR_NO_RIFF :
                                 (hdr_pos == 11) ? ERR_NO_WAVE : ERR_NO_DATA;
               end else begin
                  if (hdr_pos == 22) chans = b;
                  if (hdr_pos >= 24 && hdr_pos <= 27) rate[8*(hdr_pos-24) +: 8] = b;
                  if (hdr_pos == 34) bits = b;
                  if (hdr_pos >= 40) remaining[8*(hdr_pos-40) +: 8] = b;
                  if (hdr_pos == 43) begin
                     hit               = 1;
                     w.kind            = KIND_INFO;
                     w.channels        = chans;
                     w.sample_rate     = rate;
                     w.bits_per_sample = bits;
                     w.data_size       = remaining;
                     w.format_code     = format_now();
                     stage             = PH_PAYLOAD;
                     frame             = '0;
                     frame_pos         = 0;
                  end else begin
                     hdr_pos++;
                     if (r.last_byte) begin
                        hit          = 1;
                        w.kind       = KIND_ERROR;
                        w.error_code = ERR_TRUNCATED;
                     end
                  end
               end
            end
            PH_PAYLOAD: begin
               fmt = format_now();
               if (remaining != 0) begin
                  remaining--;
                  if (fmt != FMT_NONE) begin
                     need = (fmt == FMT_MONO8) ? 1 : (fmt == FMT_STEREO16) ? 4 : 2;
                     if (frame_pos + 1 < need) begin
                        frame[8*frame_pos +: 8] = b;
                        frame_pos++;
                     end else begin
                        case (fmt)
                           FMT_MONO8:  s = {8'h00, b};
                           FMT_MONO16: s = {b, frame[7:0]};
                           FMT_STEREO8: begin
                              sum9 = {1'b0, frame[7:0]} + {1'b0, b};
                              s    = {8'h00, sum9[8:1]};
                           end
                           default: begin
                              // signed halving truncates toward zero
                              mix = (int'($signed(frame[15:0])) +
                                     int'($signed({b, frame[23:16]}))) / 2;
                              s   = mix[15:0];
                           end
                        endcase
                        hit       = 1;
                        w.kind    = KIND_SAMPLE;
                        w.sample  = s;
                        frame     = '0;
                        frame_pos = 0;
                     end
                  end
               end
            end
            default: ;
         endcase
         if (r.last_byte) begin
            stage     = PH_HEADER;
            hdr_pos   = 0;
            tag_win   = '0;
            frame     = '0;
            frame_pos = 0;
         end
         if (hit) pending_words.push_back(w);
      endfunction

      function void check_word(rsp_type got);
         rsp_type want;
         if (pending_words.size() == 0) begin
            $error("result word with nothing expected: kind %0d", got.kind);
            errors++;
            return;
         end
         want = pending_words.pop_front();
         if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            errors++;
         end
         if (got.sample !== want.sample) begin
            $error("sample: expected %0d, got %0d", want.sample, got.sample);
            errors++;
         end
         if (got.channels !== want.channels) begin
            $error("channels: expected %0d, got %0d", want.channels, got.channels);
            errors++;
         end
         if (got.sample_rate !== want.sample_rate) begin
            $error("sample_rate: expected %0d, got %0d", want.sample_rate, got.sample_rate);
            errors++;
         end
         if (got.bits_per_sample !== want.bits_per_sample) begin
            $error("bits_per_sample: expected %0d, got %0d",
                   want.bits_per_sample, got.bits_per_sample);
            errors++;
         end
         if (got.data_size !== want.data_size) begin
            $error("data_size: expected %0d, got %0d", want.data_size, got.data_size);
            errors++;
         end
         if (got.format_code !== want.format_code) begin
            $error("format_code: expected %0d, got %0d", want.format_code, got.format_code);
            errors++;
         end
         if (got.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    push;
   logic    full;
   req_type req_item;
   logic    empty;
   logic    pop;
   rsp_type rsp_item;

   downmix_scoreboard_type sb = new();
   int cycle_count   = 0;
   bit idle_on       = 1;
   bit long_hold_req = 0;
   int gap_pct       = 10;

   wav_stream_mono_downmixer_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[wav_stream_mono_downmixer_unit] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && push && !full) sb.note_byte(req_item);
      if (!reset && pop && !empty) sb.check_word(rsp_item);
   end

   // 44-byte header: tags go out in text order, numbers little-endian
   function automatic byte_queue_type wav_header(input logic [7:0] ch, input logic [7:0] nbits,
                                                 input logic [31:0] hz,
                                                 input logic [31:0] nbytes);
      byte_queue_type h;
      logic [31:0]    w [11];
      w[0]  = TAG_RIFF;
      w[1]  = nbytes + 32'd36;
      w[2]  = TAG_WAVE;
      w[3]  = 32'h666D_7420;
      w[4]  = 32'd16;
      w[5]  = {8'($urandom), ch, 16'd1};
      w[6]  = hz;
      w[7]  = $urandom;
      w[8]  = {8'($urandom), nbits, 16'($urandom)};
      w[9]  = TAG_DATA;
      w[10] = nbytes;
      for (int i = 0; i < 11; i++)
         for (int k = 0; k < 4; k++)
            h.push_back((i == 0 || i == 2 || i == 3 || i == 9) ?
                        w[i][31-8*k -: 8] : w[i][8*k +: 8]);
      return h;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic mark);
      if (idle_on && $urandom_range(0, 99) < gap_pct) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      push     <= 1'b1;
      req_item <= '{data_byte: b, last_byte: mark};
      do @(posedge clock); while (full);
   endtask

   task automatic play_file(input byte_queue_type f, input bit mark);
      foreach (f[i]) send_byte(f[i], mark && (i == f.size() - 1));
   endtask

   task automatic play_wav(input logic [7:0] ch, input logic [7:0] nbits,
                           input logic [31:0] hz, input logic [31:0] nbytes,
                           input byte_queue_type payload);
      byte_queue_type f;
      f = wav_header(ch, nbits, hz, nbytes);
      foreach (payload[i]) f.push_back(payload[i]);
      play_file(f, 1);
   endtask

   // receiver: random stall bursts, one long hold on request
   initial begin
      int hold;
      int stall_pct;
      hold      = 0;
      stall_pct = 10;
      pop <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (cycle_count % 128 == 0) stall_pct = $urandom_range(0, 2) * 20;
         if (long_hold_req) begin
            long_hold_req = 0;
            hold          = LONG_HOLD;
         end
         if (hold > 0) begin
            pop <= 1'b0;
            hold--;
         end else if (idle_on && $urandom_range(0, 99) < stall_pct) begin
            pop  <= 1'b0;
            hold  = $urandom_range(0, 10);
         end else begin
            pop <= 1'b1;
         end
      end
   end

   initial begin
      byte_queue_type f;
      byte_queue_type p;
      int          random_bytes;
      int          pick;
      int          data_len;
      int          pos;
      bit          mark;
      logic [7:0]  ch;
      logic [7:0]  nbits;
      logic [31:0] nbytes;
      random_bytes = 0;
      reset    <= 1'b1;
      push     <= 1'b0;
      req_item <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // mono 8-bit run while the receiver holds off, so the input backs up
      long_hold_req = 1;
      p.delete();
      repeat (40) p.push_back(8'($urandom));
      play_wav(8'd1, 8'd8, 32'd8000, 32'd40, p);

      p = {8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE};
      play_wav(8'd1, 8'd8, 32'hFFFF_FFFF, 32'd6, p);
      p = {8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'hFF, 8'h7F};
      play_wav(8'd1, 8'd16, 32'd44100, 32'd8, p);
      p = {8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h01, 8'h00, 8'hFE, 8'hFF};
      play_wav(8'd2, 8'd8, 32'd22050, 32'd8, p);
      p = {8'hFF, 8'h7F, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'h00, 8'h80, 8'hFF, 8'hFF,
           8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'h01, 8'h00, 8'hFC, 8'hFF};
      play_wav(8'd2, 8'd16, 32'd48000, 32'd20, p);
      // unsupported formats swallow their payload
      p = {8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66};
      play_wav(8'd2, 8'd24, 32'd96000, 32'd6, p);
      play_wav(8'hFF, 8'hFF, 32'd0, 32'd6, p);
      // incomplete stereo frame at the end is dropped
      play_wav(8'd2, 8'd16, 32'd8000, 32'd6, p);
      // bytes past data size are ignored
      p = {8'h10, 8'h20, 8'h30, 8'h40, 8'h50};
      play_wav(8'd1, 8'd8, 32'd8000, 32'd2, p);
      // file ends in the middle of the payload
      p = {8'h34, 8'h12, 8'h56};
      play_wav(8'd1, 8'd16, 32'd8000, 32'd10, p);
      // end mark on the final header byte
      p.delete();
      play_wav(8'd1, 8'd8, 32'd11025, 32'd0, p);
      p = {8'h01, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'h80, 8'hFF};
      play_wav(8'd2, 8'd16, 32'd0, 32'hFFFF_FFFF, p);
      // one bad tag of each kind, then trailing bytes
      for (int t = 0; t < 3; t++) begin
         f = wav_header(8'd1, 8'd8, 32'd8000, 32'd4);
         pos = (t == 0) ? 1 : (t == 1) ? 10 : 38;
         f[pos] = f[pos] ^ 8'h20;
         repeat (3) f.push_back(8'($urandom));
         play_file(f, 1);
      end
      // truncated headers; a bad tag on the end byte wins over truncation
      f = wav_header(8'd1, 8'd8, 32'd8000, 32'd4);
      while (f.size() > 20) void'(f.pop_back());
      play_file(f, 1);
      while (f.size() > 4) void'(f.pop_back());
      play_file(f, 1);
      f = wav_header(8'd1, 8'd8, 32'd8000, 32'd4);
      f[11] = f[11] ^ 8'h01;
      while (f.size() > 12) void'(f.pop_back());
      play_file(f, 1);

      while (random_bytes < RANDOM_BYTES) begin
         if (random_bytes > RANDOM_BYTES - 250) idle_on = 0;
         gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 30);
         pick    = $urandom_range(0, 99);
         ch      = 8'($urandom_range(1, 2));
         nbits   = $urandom_range(0, 1) ? 8'd16 : 8'd8;
         if ($urandom_range(0, 9) == 0) begin
            ch    = 8'($urandom);
            nbits = 8'($urandom);
         end
         case ($urandom_range(0, 9))
            0:       nbytes = $urandom;
            1:       nbytes = 32'd0;
            default: nbytes = $urandom_range(1, 24);
         endcase
         data_len = (nbytes > 28) ? 28 : int'(nbytes);
         if ($urandom_range(0, 3) == 0) data_len = $urandom_range(0, data_len);
         else data_len = data_len + $urandom_range(0, 2);
         f = wav_header(ch, nbits, $urandom, nbytes);
         repeat (data_len) begin
            if ($urandom_range(0, 7) == 0)
               f.push_back($urandom_range(0, 1) ? {$urandom_range(0, 1) ? 1'b1 : 1'b0, 7'h7F}
                                               : {$urandom_range(0, 1) ? 1'b1 : 1'b0, 7'h00});
            else
               f.push_back(8'($urandom));
         end
         mark = 1;
         if (pick >= 65 && pick < 80) begin
            // flip one bit in one of the three tags
            pos = $urandom_range(0, 11);
            pos = (pos < 4) ? pos : (pos < 8) ? pos + 4 : pos + 28;
            f[pos] = f[pos] ^ (8'd1 << $urandom_range(0, 7));
         end else if (pick >= 80 && pick < 90) begin
            pos = $urandom_range(1, 43);
            while (f.size() > pos) void'(f.pop_back());
         end else if (pick >= 90 && pick < 95) begin
            // runs straight into the next file without an end mark
            mark = 0;
         end else if (pick >= 95) begin
            f.delete();
            repeat ($urandom_range(1, 16)) f.push_back(8'($urandom));
            foreach (f[i]) send_byte(f[i], $urandom_range(0, 3) == 0);
            f = {8'($urandom)};
         end
         play_file(f, mark);
         random_bytes += f.size();
      end

      push <= 1'b0;
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("[wav_stream_mono_downmixer_unit] OK");
      end else begin
         $display("[wav_stream_mono_downmixer_unit] ERROR");
      end
      $finish;
   end

endmodule

// ===== wav_stream_mono_downmixer_unit.f =====
rtl/wsmd_pkg.sv
rtl/wsmd_front.sv
rtl/wsmd_queue.sv
rtl/wsmd_back.sv
rtl/wav_stream_mono_downmixer_unit.sv
verif/tb_top.sv
